// ----- hdl/wdrf_pkg.sv -----
// Shared types and constants for the windowed dose-rate filter.
package wdrf_pkg;

    localparam int ENERGY_W   = 20;
    localparam int BIN_W      = 32;
    localparam int SUM_W      = 40;
    localparam int DOSE_W     = 48;
    localparam int SCALE_W    = 32;
    localparam int COEFF_W    = 16;
    localparam int WTICKS_W   = 7;
    localparam int HALF_W     = 20;
    localparam int PROD_W     = HALF_W + SCALE_W;
    localparam int FRAC_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [WTICKS_W-1:0] WINDOW_TICKS_RST = 7'd10;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_NGY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MGY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COEFF  = 3'd4;

    // Input action codes.
    localparam logic ACT_EVENT = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SUM  = 5'b00010,
        S_MUL  = 5'b00100,
        S_FILT = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

endpackage

// ----- hdl/wdrf_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module wdrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/windowed_dose_rate_filter_top.sv -----
// Top level of the windowed dose-rate filter: tick-bin ring, window sum, scaling, smoothing.
//
// Event beats (action 0) add a cluster energy in keV to the open tick bin, saturating at
// 32 bits, and are taken one per cycle while the block is idle; they produce no result. A
// tick beat (action 1) writes the open bin into a ring memory of WINDOW_MAX per-tick sums
// and then sums the newest window_ticks bins (0 acts as 1, values above WINDOW_MAX act as
// WINDOW_MAX), saturating at 40 bits. Bins never written since reset count as zero; a fill
// count keeps track of them, so the ring needs no clearing pass and the block is ready
// right after reset. The sum is scaled by the two Q8.24 factors with truncation, and the
// mGy/year value goes through the Q0.16 exponential smoothing filter when filter_enable is
// set. The input stays not ready from a tick beat until its result is loaded. In the
// window sweep the single read port of the ring memory delivers one bin per cycle and the
// newest bin comes from the open-bin register. The shared 20x32 multiplier then issues the
// partial products of the two scalings in turn, and a last step folds in the final one.
// The filter products are formed in S_FILT and the result is loaded in S_DONE. The result
// waits in an output register, so events are taken while it is still unclaimed; a
// following tick holds in its last step until that register is free.
// Configuration is written through a plain write port and must only change while idle.
module windowed_dose_rate_filter_top #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [wdrf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wdrf_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_action,
    input  logic [wdrf_pkg::ENERGY_W-1:0]     i_energy_kev,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [wdrf_pkg::DOSE_W-1:0]       o_dose_ngy_per_sec,
    output logic [wdrf_pkg::DOSE_W-1:0]       o_dose_mgy_per_year
);

    import wdrf_pkg::*;

    // Ring address width and a count width that can hold WINDOW_MAX itself.
    localparam int AW = $clog2(WINDOW_MAX);
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int LW = (CW > WTICKS_W) ? CW : WTICKS_W;
    localparam logic [AW-1:0] POS_LAST = AW'(WINDOW_MAX - 1);
    localparam logic [LW-1:0] WMAX_L   = LW'(WINDOW_MAX);

    // Configuration registers.
    logic [WTICKS_W-1:0] r_window_ticks;
    logic [SCALE_W-1:0]  r_scale_ngy;
    logic [SCALE_W-1:0]  r_scale_mgy;
    logic                r_filter_enable;
    logic [COEFF_W-1:0]  r_filter_coeff;

    // Control and persistent state.
    t_state              r_state;
    logic [BIN_W-1:0]    r_open_bin;
    logic [AW-1:0]       r_pos;
    logic [CW-1:0]       r_fill;
    logic [AW-1:0]       r_rd_idx;
    logic [CW-1:0]       r_left;
    logic                r_pend;
    logic [2:0]          r_mstep;
    logic [DOSE_W-1:0]   r_filtered;
    logic                r_out_valid;

    // Datapath registers.
    logic [SUM_W-1:0]    r_sum;
    logic [PROD_W-1:0]   r_prod;
    logic [PROD_W-1:0]   r_hi;
    logic [DOSE_W-1:0]   r_ngy;
    logic [DOSE_W-1:0]   r_mgy;
    logic [63:0]         r_fa;
    logic [64:0]         r_fb;
    logic [DOSE_W-1:0]   r_out_ngy;
    logic [DOSE_W-1:0]   r_out_mgy;

    logic                in_fire;
    logic                out_fire;
    logic                tick_fire;
    logic                done_go;
    logic [BIN_W:0]      bin_add;
    logic [BIN_W-1:0]    n_open_bin;
    logic [LW-1:0]       w_ext;
    logic [LW-1:0]       w_eff;
    logic [LW-1:0]       fill_next;
    logic [LW-1:0]       n_count;
    logic [BIN_W-1:0]    rd_data;
    logic [SUM_W:0]      sum_add;
    logic [SUM_W-1:0]    n_sum;
    logic [HALF_W-1:0]   mul_a;
    logic [SCALE_W-1:0]  mul_s;
    logic [PROD_W-1:0]   n_prod;
    logic [PROD_W:0]     low_sum;
    logic [DOSE_W-1:0]   scaled;
    logic [16:0]         coeff_c;
    logic [64:0]         filt_sum;
    logic [DOSE_W-1:0]   n_filtered;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign tick_fire  = in_fire && (i_action == ACT_TICK);
    assign out_fire   = r_out_valid && i_out_ready;
    assign done_go    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Saturating accumulation into the open bin.
    assign bin_add    = {1'b0, r_open_bin} + (BIN_W + 1)'(i_energy_kev);
    assign n_open_bin = bin_add[BIN_W] ? {BIN_W{1'b1}} : bin_add[BIN_W-1:0];

    // Effective window length, limited by the number of bins written since reset.
    always_comb begin
        w_ext = LW'(r_window_ticks);
        if (w_ext == '0) begin
            w_eff = LW'(1);
        end else if (w_ext > WMAX_L) begin
            w_eff = WMAX_L;
        end else begin
            w_eff = w_ext;
        end
        fill_next = (LW'(r_fill) == WMAX_L) ? WMAX_L : LW'(r_fill) + LW'(1);
        n_count   = (w_eff < fill_next) ? w_eff : fill_next;
    end

    // The newest bin is taken straight from the open-bin register; older ones come from the
    // ring, one read per cycle walking backward from the previous position.
    wdrf_ram #(
        .WIDTH (BIN_W),
        .DEPTH (WINDOW_MAX)
    ) u_bins (
        .i_clk     (i_clk),
        .i_wr_en   (tick_fire),
        .i_wr_addr (r_pos),
        .i_wr_data (r_open_bin),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (rd_data)
    );

    assign sum_add = {1'b0, r_sum} + (SUM_W + 1)'(rd_data);
    assign n_sum   = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

    // Shared multiplier. Step order: high half by nGy scale, low half by nGy scale,
    // high half by mGy scale, low half by mGy scale.
    assign mul_a  = r_mstep[0] ? r_sum[HALF_W-1:0] : r_sum[SUM_W-1:HALF_W];
    assign mul_s  = r_mstep[1] ? r_scale_mgy : r_scale_ngy;
    assign n_prod = {{SCALE_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_s};

    // floor((hi * 2^20 + lo) / 2^24); the product of a 40-bit sum and a 32-bit factor
    // shifted down by 24 always fits in 48 bits.
    assign low_sum = {{(PROD_W - FRAC_W + 1){1'b0}}, r_hi[3:0], {HALF_W{1'b0}}}
                   + {1'b0, r_prod};
    assign scaled  = r_hi[PROD_W-1:4]
                   + {{(DOSE_W - (PROD_W + 1 - FRAC_W)){1'b0}}, low_sum[PROD_W:FRAC_W]};

    assign coeff_c    = 17'h10000 - {1'b0, r_filter_coeff};
    assign filt_sum   = {1'b0, r_fa} + r_fb;
    assign n_filtered = r_filter_enable ? filt_sum[63:16] : r_mgy;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ticks  <= WINDOW_TICKS_RST;
            r_scale_ngy     <= '0;
            r_scale_mgy     <= '0;
            r_filter_enable <= 1'b0;
            r_filter_coeff  <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_WINDOW_TICKS:  r_window_ticks  <= i_cfg_wdata[WTICKS_W-1:0];
                CFG_SCALE_NGY:     r_scale_ngy     <= i_cfg_wdata[SCALE_W-1:0];
                CFG_SCALE_MGY:     r_scale_mgy     <= i_cfg_wdata[SCALE_W-1:0];
                CFG_FILTER_ENABLE: r_filter_enable <= i_cfg_wdata[0];
                CFG_FILTER_COEFF:  r_filter_coeff  <= i_cfg_wdata[COEFF_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and persistent state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_open_bin  <= '0;
            r_pos       <= '0;
            r_fill      <= '0;
            r_rd_idx    <= '0;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_mstep     <= '0;
            r_filtered  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A result loaded in this cycle keeps the output valid.
            if (out_fire && !done_go) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_action == ACT_TICK) begin
                            r_open_bin <= '0;
                            r_pos      <= (r_pos == POS_LAST) ? '0 : r_pos + AW'(1);
                            r_fill     <= CW'(fill_next);
                            r_rd_idx   <= (r_pos == '0) ? POS_LAST : r_pos - AW'(1);
                            r_left     <= CW'(n_count - LW'(1));
                            r_pend     <= 1'b0;
                            r_mstep    <= '0;
                            r_state    <= S_SUM;
                        end else begin
                            r_open_bin <= n_open_bin;
                        end
                    end
                end
                S_SUM: begin
                    if (r_left != '0) begin
                        r_left   <= r_left - CW'(1);
                        r_rd_idx <= (r_rd_idx == '0) ? POS_LAST : r_rd_idx - AW'(1);
                        r_pend   <= 1'b1;
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_mstep <= r_mstep + 3'd1;
                    if (r_mstep == 3'd4) begin
                        r_state <= S_FILT;
                    end
                end
                S_FILT: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (done_go) begin
                        r_filtered  <= n_filtered;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (tick_fire) begin
            r_sum <= SUM_W'(r_open_bin);
        end else if ((r_state == S_SUM) && r_pend) begin
            r_sum <= n_sum;
        end

        if (r_state == S_MUL) begin
            r_prod <= n_prod;
            // Fold in the product issued in the previous step.
            case (r_mstep)
                3'd1, 3'd3: r_hi  <= r_prod;
                3'd2:       r_ngy <= scaled;
                3'd4:       r_mgy <= scaled;
                default: ;
            endcase
        end

        if (r_state == S_FILT) begin
            r_fa <= {{(64 - COEFF_W){1'b0}}, r_filter_coeff} * {{COEFF_W{1'b0}}, r_filtered};
            r_fb <= {{(65 - 17){1'b0}}, coeff_c} * {{17{1'b0}}, r_mgy};
        end

        if (done_go) begin
            r_out_ngy <= r_ngy;
            r_out_mgy <= n_filtered;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_dose_ngy_per_sec  = r_out_ngy;
    assign o_dose_mgy_per_year = r_out_mgy;

    // The fill count never passes the ring depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_fill) <= WMAX_L)
        else $error("tick-bin fill count exceeds ring depth");

    // A tick beat always starts a window sweep.
    a_tick_starts_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_fire |=> (r_state == S_SUM))
        else $error("tick beat did not start the window sweep");

    // A new result appears only from the final step of a tick.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid || out_fire) ##1 r_out_valid |-> $past(r_state == S_DONE))
        else $error("result raised outside the final tick step");

    // An unclaimed result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_out_mgy) && $stable(r_out_ngy))
        else $error("pending result overwritten");

endmodule

// ----- dv/tb_windowed_dose_rate_filter_top.sv -----
// Self-checking testbench for the windowed dose-rate filter: directed, heavy-bin and random beats.
module tb_windowed_dose_rate_filter_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wdrf_pkg::*;

    localparam int WINDOW_MAX = 64;
    localparam int RING_AW = $clog2(WINDOW_MAX);

    // This margin covers any work still in flight once the last expected dose has come out.
    localparam int SETTLE_CYCLES = WINDOW_MAX + 40;

    // Cycle limit for the whole run; a correct run ends well before it.
    localparam int RUN_LIMIT = 400000;

    localparam logic [SUM_W:0] SUM_CAP = {1'b0, {SUM_W{1'b1}}};
    localparam logic [ENERGY_W-1:0] KEV_MAX = {ENERGY_W{1'b1}};
    localparam logic [SCALE_W-1:0] SCALE_ONE = 32'h0100_0000;
    localparam logic [SCALE_W-1:0] SCALE_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [DOSE_W-1:0] ngy;
        logic [DOSE_W-1:0] mgy;
    } dose_pair_t;

    // Clock, reset and every input of the block start from known values.
    logic i_clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_action = ACT_EVENT;
    logic [ENERGY_W-1:0] in_energy = '0;
    logic out_ready = 1'b0;

    logic o_in_ready;
    logic o_out_valid;
    logic [DOSE_W-1:0] o_dose_ngy_per_sec;
    logic [DOSE_W-1:0] o_dose_mgy_per_year;

    // Percentages of cycles in which the sender holds back or the receiver stalls.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    // Doses predicted for accepted ticks, oldest first.
    dose_pair_t pending_doses[$];

    // Our own copy of the meter: configuration and state.
    logic [WTICKS_W-1:0] m_window = WINDOW_TICKS_RST;
    logic [SCALE_W-1:0] m_scale_ngy = '0;
    logic [SCALE_W-1:0] m_scale_mgy = '0;
    logic m_filt_en = 1'b0;
    logic [COEFF_W-1:0] m_coeff = '0;
    logic [BIN_W-1:0] m_open_bin = '0;
    logic [BIN_W-1:0] m_bins [WINDOW_MAX];
    logic [RING_AW-1:0] m_ring_pos = '0;
    logic [DOSE_W-1:0] m_filtered = '0;

    windowed_dose_rate_filter_top #(
        .WINDOW_MAX(WINDOW_MAX)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (rst_n),
        .i_cfg_wr_en        (cfg_wr_en),
        .i_cfg_index        (cfg_index),
        .i_cfg_wdata        (cfg_wdata),
        .i_in_valid         (in_valid),
        .o_in_ready         (o_in_ready),
        .i_action           (in_action),
        .i_energy_kev       (in_energy),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (out_ready),
        .o_dose_ngy_per_sec (o_dose_ngy_per_sec),
        .o_dose_mgy_per_year(o_dose_mgy_per_year)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < WINDOW_MAX; i++) begin
            m_bins[RING_AW'(i)] = '0;
        end
    end

    // Run limit: a hung handshake ends the run here as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // The receiver stalls at random, at the rate the current phase asks for.
    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Floor of a Q8.24 scaling. The window sum is below 2^40 and the factor below 2^32,
    // so the product fits in 72 bits and its top 48 bits never need saturating.
    function automatic logic [DOSE_W-1:0] q24_scale(input logic [SUM_W-1:0] kev_sum,
                                                    input logic [SCALE_W-1:0] factor);
        logic [SUM_W+SCALE_W-1:0] prod;
        prod = {{SCALE_W{1'b0}}, kev_sum} * {{SUM_W{1'b0}}, factor};
        return prod[SUM_W+SCALE_W-1 -: DOSE_W];
    endfunction

    // Applies one accepted beat to the meter copy. An event grows the open bin; a tick
    // closes it into the ring, sums the window, scales, smooths and queues the dose pair.
    task automatic update_dose_meter(input logic act, input logic [ENERGY_W-1:0] kev);
        logic [BIN_W:0] grown;
        logic [SUM_W:0] wsum;
        logic [65:0] blend;
        logic [DOSE_W-1:0] raw_mgy;
        dose_pair_t fresh;
        int span;
        if (act == ACT_EVENT) begin
            grown = {1'b0, m_open_bin} + {{(BIN_W + 1 - ENERGY_W){1'b0}}, kev};
            m_open_bin = grown[BIN_W] ? {BIN_W{1'b1}} : grown[BIN_W-1:0];
        end else begin
            m_bins[m_ring_pos] = m_open_bin;
            m_open_bin = '0;
            // A window of zero acts as one; anything past the ring depth acts as the depth.
            if (m_window == 0) begin
                span = 1;
            end else if (m_window > WINDOW_MAX) begin
                span = WINDOW_MAX;
            end else begin
                span = int'(m_window);
            end
            wsum = '0;
            for (int i = 0; i < span; i++) begin
                wsum = wsum + {{(SUM_W + 1 - BIN_W){1'b0}},
                               m_bins[RING_AW'((int'(m_ring_pos) + WINDOW_MAX - i)
                                               % WINDOW_MAX)]};
                if (wsum > SUM_CAP) begin
                    wsum = SUM_CAP;
                end
            end
            m_ring_pos = RING_AW'((int'(m_ring_pos) + 1) % WINDOW_MAX);
            fresh.ngy = q24_scale(wsum[SUM_W-1:0], m_scale_ngy);
            raw_mgy = q24_scale(wsum[SUM_W-1:0], m_scale_mgy);
            if (m_filt_en) begin
                blend = {50'd0, m_coeff} * {18'd0, m_filtered}
                      + ({49'd0, 17'h10000} - {50'd0, m_coeff}) * {18'd0, raw_mgy};
                m_filtered = blend[DOSE_W+15:16];
            end else begin
                m_filtered = raw_mgy;
            end
            fresh.mgy = m_filtered;
            pending_doses.insert(pending_doses.size(), fresh);
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [DOSE_W-1:0] got,
                                 input logic [DOSE_W-1:0] want);
        $display("MISMATCH at cycle %0d: %s got %0d expected %0d",
                 cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Every dose beat the receiver takes is compared with the oldest predicted pair.
    always @(posedge i_clk) begin : check_doses
        dose_pair_t due;
        if (rst_n && o_out_valid === 1'b1 && out_ready) begin
            if (pending_doses.size() == 0) begin
                flag_mismatch("dose beat with none pending, nGy/s", o_dose_ngy_per_sec, '0);
            end else begin
                due = pending_doses.pop_front();
                if (o_dose_ngy_per_sec !== due.ngy) begin
                    flag_mismatch("dose_ngy_per_sec", o_dose_ngy_per_sec, due.ngy);
                end
                if (o_dose_mgy_per_year !== due.mgy) begin
                    flag_mismatch("dose_mgy_per_year", o_dose_mgy_per_year, due.mgy);
                end
            end
        end
    end

    // Writes one register and mirrors it in the meter copy. Only called while idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_WINDOW_TICKS: begin
                m_window = value[WTICKS_W-1:0];
            end
            CFG_SCALE_NGY: begin
                m_scale_ngy = value[SCALE_W-1:0];
            end
            CFG_SCALE_MGY: begin
                m_scale_mgy = value[SCALE_W-1:0];
            end
            CFG_FILTER_ENABLE: begin
                m_filt_en = value[0];
            end
            CFG_FILTER_COEFF: begin
                m_coeff = value[COEFF_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    task automatic apply_settings(input logic [WTICKS_W-1:0] win,
                                  input logic [SCALE_W-1:0] ngy,
                                  input logic [SCALE_W-1:0] mgy,
                                  input logic en,
                                  input logic [COEFF_W-1:0] coeff);
        write_reg(CFG_WINDOW_TICKS, CFG_DATA_W'(win));
        write_reg(CFG_SCALE_NGY, ngy);
        write_reg(CFG_SCALE_MGY, mgy);
        write_reg(CFG_FILTER_ENABLE, CFG_DATA_W'(en));
        write_reg(CFG_FILTER_COEFF, CFG_DATA_W'(coeff));
    endtask

    // Presents one beat and holds it until accepted. Idle cycles come first, so valid is
    // never dropped and raised in the same step, and back-to-back beats keep valid high.
    task automatic send_beat(input logic act, input logic [ENERGY_W-1:0] kev);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_action <= act;
        in_energy <= kev;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        update_dose_meter(act, kev);
    endtask

    // Stops sending, waits until every predicted dose has come out, then lets any
    // trailing work finish so the block is idle for configuration.
    task automatic wait_for_idle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_doses.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Extremes, the saturating and clamped corners, and the smoothing filter, beat by beat.
    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // Reset configuration: an early tick whose window reaches back before reset.
        send_beat(ACT_TICK, '0);
        wait_for_idle();

        apply_settings(7'd3, SCALE_ONE, SCALE_MAX, 1'b0, 16'd0);
        send_beat(ACT_EVENT, '0);
        send_beat(ACT_EVENT, KEV_MAX);
        send_beat(ACT_EVENT, KEV_MAX);
        send_beat(ACT_TICK, KEV_MAX);
        send_beat(ACT_TICK, '0);
        send_beat(ACT_EVENT, 20'hAAAAA);
        send_beat(ACT_EVENT, 20'h55555);
        send_beat(ACT_TICK, 20'h55555);
        send_beat(ACT_TICK, 20'hAAAAA);
        wait_for_idle();

        // A window of zero behaves as a single tick.
        write_reg(CFG_WINDOW_TICKS, '0);
        send_beat(ACT_EVENT, 20'd1);
        send_beat(ACT_TICK, '0);
        wait_for_idle();

        // A window past the ring depth behaves as the full ring.
        write_reg(CFG_WINDOW_TICKS, CFG_DATA_W'(7'd127));
        write_reg(CFG_SCALE_NGY, SCALE_MAX);
        send_beat(ACT_TICK, '0);
        wait_for_idle();

        // Smoothing at half weight, then nearly full weight on the old value, then none.
        apply_settings(7'd4, SCALE_ONE, SCALE_MAX, 1'b1, 16'h8000);
        send_beat(ACT_EVENT, 20'h12345);
        send_beat(ACT_TICK, '0);
        send_beat(ACT_TICK, '0);
        wait_for_idle();
        write_reg(CFG_FILTER_COEFF, CFG_DATA_W'(16'hFFFF));
        send_beat(ACT_EVENT, KEV_MAX);
        send_beat(ACT_TICK, '0);
        wait_for_idle();
        write_reg(CFG_FILTER_COEFF, '0);
        send_beat(ACT_TICK, '0);
        wait_for_idle();
    endtask

    // Many full-scale events gathered in one bin, then a full-ring window at the
    // largest nGy scale, followed by a nearly empty bin.
    task automatic test_heavy_bin();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        apply_settings(7'd64, SCALE_MAX, SCALE_ONE, 1'b0, 16'd0);
        for (int n = 0; n < 60; n++) begin
            send_beat(ACT_EVENT, KEV_MAX);
        end
        send_beat(ACT_TICK, '0);
        send_beat(ACT_EVENT, 20'd7);
        send_beat(ACT_TICK, '0);
        wait_for_idle();
    endtask

    // New values for every register, leaning toward the extremes.
    task automatic randomize_settings();
        logic [WTICKS_W-1:0] win;
        logic [SCALE_W-1:0] scale_pick [2];
        logic [COEFF_W-1:0] coeff;
        case ($urandom_range(5))
            0: win = 7'd0;
            1: win = 7'd1;
            2: win = 7'd64;
            3: win = WTICKS_W'($urandom_range(127, 65));
            default: win = WTICKS_W'($urandom_range(16, 2));
        endcase
        for (int i = 0; i < 2; i++) begin
            case ($urandom_range(3))
                0: scale_pick[i] = '0;
                1: scale_pick[i] = SCALE_MAX;
                2: scale_pick[i] = SCALE_ONE;
                default: scale_pick[i] = $urandom;
            endcase
        end
        case ($urandom_range(2))
            0: coeff = '0;
            1: coeff = 16'hFFFF;
            default: coeff = COEFF_W'($urandom);
        endcase
        apply_settings(win, scale_pick[0], scale_pick[1], 1'($urandom_range(1)), coeff);
    endtask

    // Random traffic with the given sender idling and receiver stalls. Halfway through the sender pauses until
    // every dose is out, and the registers take new values.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int beats);
        logic [ENERGY_W-1:0] kev;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        randomize_settings();
        for (int n = 0; n < beats; n++) begin
            if (n == beats / 2) begin
                wait_for_idle();
                randomize_settings();
            end
            case ($urandom_range(3))
                0: kev = KEV_MAX;
                1: kev = '0;
                2: kev = ENERGY_W'($urandom_range(1023));
                default: kev = ENERGY_W'($urandom);
            endcase
            send_beat(($urandom_range(99) < 30) ? ACT_TICK : ACT_EVENT, kev);
        end
        wait_for_idle();
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        rst_n <= 1'b1;
        test_directed();
        test_heavy_bin();
        test_random_traffic(0, 0, 80);
        test_random_traffic(81, 0, 80);
        test_random_traffic(0, 81, 80);
        test_random_traffic(23, 23, 80);
        wait_for_idle();
        if (mismatch_count == 0 && pending_doses.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
